// File: rtl/tcp_pkg.sv
// shared types and constants for the triangle cull and projection core
// no dependencies
package tcp_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_DRAWN      = 2'd0,
		ST_CULLED     = 2'd1,
		ST_ZERO_DEPTH = 2'd2,
		ST_SATURATED  = 2'd3
	} status_t;

	// configuration register map, index is paddr[3:2]
	localparam int          APB_ADDR_W  = 4;
	localparam int          APB_DATA_W  = 32;
	localparam logic [1:0]  REG_CAM_X   = 2'd0;
	localparam logic [1:0]  REG_CAM_Y   = 2'd1;
	localparam logic [1:0]  REG_CAM_Z   = 2'd2;
	localparam logic [1:0]  REG_FOCAL   = 2'd3;

	// focal distance after reset, before masking to its width
	localparam logic [31:0] FOCAL_RESET = 32'd4096;

	// quotient bits resolved per divider stage
	localparam int          DIV_BPS     = 4;

endpackage

// File: rtl/triangle_cull_and_project_core.sv
// triangle backface cull and perspective projection, top level
// depends on tcp_pkg
//
// One triangle (three signed Q.4 vertices) enters per beat on the slave stream and one
// result (status plus three projected vertices) leaves per beat on the master stream.
// Throughput is one triangle per clock while m_tready is not held low; each beat passes
// through stages s1 to s3, ND divider stages and the output register, where ND = ceil(2*COORD_BITS / 4)
// is the number of radix-16 restoring divider stages (8 at the default width). The six projection
// quotients run through six parallel divider lanes, the cull test (sign of the normal
// dotted with the view vector) runs beside them in the first two divider stages.
// Every stage has its own valid bit and advances when its successor has room, so a
// stalled output fills bubbles before input is refused. Camera and focal distance are to be
// written over the APB port only while the block is idle; the block does not enforce it.
module triangle_cull_and_project_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream: p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z from bit 0 up
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// output stream: status screen0_x screen0_y screen1_x screen1_y screen2_x screen2_y
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((6*COORD_BITS+2+7)/8)*8-1:0]   m_tdata,
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tcp_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [tcp_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [tcp_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import tcp_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int DW    = C + 1;           // coordinate difference
	localparam int PW    = 2 * C + 2;       // edge product
	localparam int NW    = 2 * C + 3;       // normal component
	localparam int FW    = 2 * C + 1;       // focal times difference, signed
	localparam int MW    = 2 * C;           // magnitude of the dividend
	localparam int ND    = (MW + DIV_BPS - 1) / DIV_BPS;
	localparam int QW    = ND * DIV_BPS;    // padded dividend / quotient
	localparam int RW    = C + 2;           // partial remainder
	localparam int DPW   = 3 * C + 4;       // normal times view component
	localparam int SW    = 3 * C + 6;       // dot product
	localparam int OUT_W = ((6 * C + 2 + 7) / 8) * 8;
	localparam int L     = ND + 4;          // s1..s3, divider stages, output register

	localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (C - 1)) - 64'd1);
	localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (C - 1));
	localparam logic [C-1:0]  SAT_MAX = {1'b0, {(C - 1){1'b1}}};
	localparam logic [C-1:0]  SAT_MIN = {1'b1, {(C - 1){1'b0}}};

	// configuration registers
	logic [C-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [C-2:0] focal_q;
	logic [1:0]   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			focal_q <= FOCAL_RESET[C-2:0];
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_CAM_X: cam_x_q <= pwdata[C-1:0];
				REG_CAM_Y: cam_y_q <= pwdata[C-1:0];
				REG_CAM_Z: cam_z_q <= pwdata[C-1:0];
				REG_FOCAL: focal_q <= pwdata[C-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CAM_X: prdata = APB_DATA_W'(cam_x_q);
			REG_CAM_Y: prdata = APB_DATA_W'(cam_y_q);
			REG_CAM_Z: prdata = APB_DATA_W'(cam_z_q);
			REG_FOCAL: prdata = APB_DATA_W'(focal_q);
			default:   prdata = '0;
		endcase
	end

	// pipeline flow control: a stage advances when empty or when its successor advances
	logic [L-1:0] vld;
	logic [L-1:0] adv;

	always_comb begin
		adv[L-1] = !vld[L-1] || m_tready;
		for (int k = L - 2; k >= 0; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[0]) vld[0] <= s_tvalid;
			for (int k = 1; k < L; k++) begin
				if (adv[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// stage 1: edges, view vector, numerators and depths
	logic signed [DW-1:0] pv [9];
	logic signed [DW-1:0] cxe, cye, cze;
	logic signed [DW-1:0] e1_s1 [3], e2_s1 [3], dv_s1 [3], num_s1 [6], den_s1 [3];
	logic                 zero_s1;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			pv[i] = DW'($signed(s_tdata[i*C +: C]));
		end
		cxe = DW'($signed(cam_x_q));
		cye = DW'($signed(cam_y_q));
		cze = DW'($signed(cam_z_q));
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int j = 0; j < 3; j++) begin
				e1_s1[j]    <= pv[3+j] - pv[j];
				e2_s1[j]    <= pv[6+j] - pv[j];
				num_s1[2*j]   <= cxe - pv[3*j];
				num_s1[2*j+1] <= cye - pv[3*j+1];
				den_s1[j]     <= cze - pv[3*j+2];
			end
			dv_s1[0] <= cxe - pv[0];
			dv_s1[1] <= cye - pv[1];
			dv_s1[2] <= cze - pv[2];
			zero_s1  <= (cze == pv[2]) || (cze == pv[5]) || (cze == pv[8]);
		end
	end

	// stage 2: edge products for the normal, focal products for the projection
	logic signed [PW-1:0] pr_s2 [6];
	logic signed [FW-1:0] fp_s2 [6];
	logic signed [DW-1:0] den_s2 [3], dv_s2 [3];
	logic                 zero_s2;
	logic signed [FW-1:0] focal_ext;

	assign focal_ext = FW'($signed({1'b0, focal_q}));

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pr_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
			pr_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[1]);
			pr_s2[2] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
			pr_s2[3] <= PW'(e1_s1[0]) * PW'(e2_s1[2]);
			pr_s2[4] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
			pr_s2[5] <= PW'(e1_s1[1]) * PW'(e2_s1[0]);
			for (int k = 0; k < 6; k++) begin
				fp_s2[k] <= focal_ext * FW'(num_s1[k]);
			end
			den_s2  <= den_s1;
			dv_s2   <= dv_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: normal components, dividend and divisor magnitudes, quotient signs
	logic signed [NW-1:0] n_s3 [3];
	logic signed [DW-1:0] dv_s3 [3];
	logic [MW-1:0]        nmag_s3 [6];
	logic [DW-1:0]        dmag_s3 [3];
	logic [5:0]           qneg_s3;
	logic                 zero_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				n_s3[i]    <= NW'(pr_s2[2*i]) - NW'(pr_s2[2*i+1]);
				dmag_s3[i] <= den_s2[i][DW-1] ? DW'(-den_s2[i]) : DW'(den_s2[i]);
			end
			for (int k = 0; k < 6; k++) begin
				nmag_s3[k] <= fp_s2[k][FW-1] ? MW'(-fp_s2[k]) : MW'(fp_s2[k]);
				qneg_s3[k] <= fp_s2[k][FW-1] ^ den_s2[k/2][DW-1];
			end
			dv_s3   <= dv_s2;
			zero_s3 <= zero_s2;
		end
	end

	// divider stages: six restoring lanes, DIV_BPS quotient bits per stage
	logic [RW-1:0]        rem_d  [ND][6];
	logic [QW-1:0]        quo_d  [ND][6];
	logic [DW-1:0]        dmag_d [ND][3];
	logic [5:0]           qneg_d [ND];
	logic [ND-1:0]        zero_d;
	logic [ND-1:0]        cull_d;
	logic signed [DPW-1:0] dprod_s4 [3];

	logic [RW-1:0] rem_nx [ND][6];
	logic [QW-1:0] quo_nx [ND][6];

	always_comb begin
		logic [RW-1:0] r;
		logic [QW-1:0] q;
		logic [DW-1:0] dm;
		for (int j = 0; j < ND; j++) begin
			for (int k = 0; k < 6; k++) begin
				if (j == 0) begin
					r  = '0;
					q  = QW'(nmag_s3[k]);
					dm = dmag_s3[k/2];
				end else begin
					r  = rem_d[j-1][k];
					q  = quo_d[j-1][k];
					dm = dmag_d[j-1][k/2];
				end
				for (int b = 0; b < DIV_BPS; b++) begin
					r = {r[RW-2:0], q[QW-1]};
					q = {q[QW-2:0], 1'b0};
					if (r >= RW'(dm)) begin
						r    = r - RW'(dm);
						q[0] = 1'b1;
					end
				end
				rem_nx[j][k] = r;
				quo_nx[j][k] = q;
			end
		end
	end

	logic signed [SW-1:0] dot_sum;

	assign dot_sum = SW'(dprod_s4[0]) + SW'(dprod_s4[1]) + SW'(dprod_s4[2]);

	always_ff @(posedge clk) begin
		for (int j = 0; j < ND; j++) begin
			if (adv[3+j]) begin
				rem_d[j] <= rem_nx[j];
				quo_d[j] <= quo_nx[j];
				if (j == 0) begin
					dmag_d[j] <= dmag_s3;
					qneg_d[j] <= qneg_s3;
					zero_d[j] <= zero_s3;
					cull_d[j] <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						dprod_s4[i] <= DPW'(n_s3[i]) * DPW'(dv_s3[i]);
					end
				end else begin
					dmag_d[j] <= dmag_d[j-1];
					qneg_d[j] <= qneg_d[j-1];
					zero_d[j] <= zero_d[j-1];
					// negative dot product: facing away from the camera
					cull_d[j] <= (j == 1) ? dot_sum[SW-1] : cull_d[j-1];
				end
			end
		end
	end

	// output stage: sign, saturation, status priority
	logic [C-1:0] scr_val [6];
	logic [5:0]   sat_lane;
	status_t      status_nx;
	status_t      status_q;
	logic [C-1:0] scr_q [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			sat_lane[k] = 1'b0;
			if (!qneg_d[ND-1][k]) begin
				if (quo_d[ND-1][k] > POS_LIM) begin
					sat_lane[k] = 1'b1;
					scr_val[k]  = SAT_MAX;
				end else begin
					scr_val[k]  = quo_d[ND-1][k][C-1:0];
				end
			end else begin
				if (quo_d[ND-1][k] > NEG_LIM) begin
					sat_lane[k] = 1'b1;
					scr_val[k]  = SAT_MIN;
				end else begin
					scr_val[k]  = -quo_d[ND-1][k][C-1:0];
				end
			end
		end
		if (cull_d[ND-1])            status_nx = ST_CULLED;
		else if (zero_d[ND-1])       status_nx = ST_ZERO_DEPTH;
		else if (|sat_lane)          status_nx = ST_SATURATED;
		else                         status_nx = ST_DRAWN;
	end

	always_ff @(posedge clk) begin
		if (adv[L-1]) begin
			status_q <= status_nx;
			for (int k = 0; k < 6; k++) begin
				scr_q[k] <= (status_nx == ST_CULLED || status_nx == ST_ZERO_DEPTH)
					? '0 : scr_val[k];
			end
		end
	end

	always_comb begin
		m_tdata      = '0;
		m_tdata[1:0] = status_q;
		for (int k = 0; k < 6; k++) begin
			m_tdata[2 + k*C +: C] = scr_q[k];
		end
	end

`ifndef SYNTHESIS
	// culled and zero-depth results never carry coordinates
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_CULLED || m_tdata[1:0] == ST_ZERO_DEPTH)
		|-> m_tdata[OUT_W-1:2] == '0)
		else $error("rejected triangle carries coordinates");

	// input is refused only while the first stage holds an item
	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld[0])
		else $error("input refused with empty first stage");

	// a stalled result is neither lost nor altered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[L-1] && !m_tready |=> vld[L-1] && $stable(m_tdata))
		else $error("stalled result changed");
`endif

endmodule
